// ===== hdl/macdh_pkg.sv =====
// Shared types, constants and the microcode table of the MACD histogram filter.
package macdh_pkg;

   localparam int AVG_EXTRA     = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int PERIOD_LONG   = 26;
   localparam int PERIOD_SHORT  = 12;
   localparam int PERIOD_SIGNAL = 9;
   localparam int PC_BITS       = 5;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_DIFF,
      OP_MUL_HI,
      OP_MUL_LO,
      OP_ACC,
      OP_UPDATE,
      OP_MACD,
      OP_HIST,
      OP_SEED
   } op_type;

   typedef enum logic [1:0] {
      SEL_LONG,
      SEL_SHORT,
      SEL_SIGNAL
   } sel_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_OUT_BUSY
   } hold_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_SEED,
      JMP_ALWAYS
   } jump_type;

   localparam logic [PC_BITS-1:0] STEP_LOAD = 5'd0;
   localparam logic [PC_BITS-1:0] STEP_HIST = 5'd17;
   localparam logic [PC_BITS-1:0] STEP_SEED = 5'd18;
   localparam logic [PC_BITS-1:0] STEP_LAST = STEP_SEED;

   typedef struct packed {
      op_type             op;
      sel_type            sel;
      hold_type           hold;
      jump_type           jump;
      logic [PC_BITS-1:0] target;
   } uword_type;

   typedef struct packed {
      op_type  op;
      sel_type sel;
      logic    load;
      logic    advance;
   } ctrl_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   function automatic uword_type uword(input op_type op, input sel_type sel,
                                       input hold_type hold, input jump_type jump,
                                       input logic [PC_BITS-1:0] target);
      uword_type w;
      w.op     = op;
      w.sel    = sel;
      w.hold   = hold;
      w.jump   = jump;
      w.target = target;
      return w;
   endfunction

   function automatic uword_type ucode_fetch(input logic [PC_BITS-1:0] pc);
      uword_type w;
      case (pc)
         5'd0:  w = uword(OP_LOAD,   SEL_LONG,   HOLD_NO_REQ,   JMP_NONE,   STEP_LOAD);
         5'd1:  w = uword(OP_DIFF,   SEL_LONG,   HOLD_NONE,     JMP_SEED,   STEP_SEED);
         5'd2:  w = uword(OP_MUL_HI, SEL_LONG,   HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd3:  w = uword(OP_MUL_LO, SEL_LONG,   HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd4:  w = uword(OP_ACC,    SEL_LONG,   HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd5:  w = uword(OP_UPDATE, SEL_LONG,   HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd6:  w = uword(OP_DIFF,   SEL_SHORT,  HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd7:  w = uword(OP_MUL_HI, SEL_SHORT,  HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd8:  w = uword(OP_MUL_LO, SEL_SHORT,  HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd9:  w = uword(OP_ACC,    SEL_SHORT,  HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd10: w = uword(OP_UPDATE, SEL_SHORT,  HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd11: w = uword(OP_MACD,   SEL_SIGNAL, HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd12: w = uword(OP_DIFF,   SEL_SIGNAL, HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd13: w = uword(OP_MUL_HI, SEL_SIGNAL, HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd14: w = uword(OP_MUL_LO, SEL_SIGNAL, HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd15: w = uword(OP_ACC,    SEL_SIGNAL, HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd16: w = uword(OP_UPDATE, SEL_SIGNAL, HOLD_NONE,     JMP_NONE,   STEP_LOAD);
         5'd17: w = uword(OP_HIST,   SEL_SIGNAL, HOLD_OUT_BUSY, JMP_ALWAYS, STEP_LOAD);
         5'd18: w = uword(OP_SEED,   SEL_LONG,   HOLD_NONE,     JMP_ALWAYS, STEP_HIST);
         default: w = uword(OP_MACD, SEL_LONG,   HOLD_NONE,     JMP_ALWAYS, STEP_LOAD);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/macdh_if.sv =====
// Request and response channel interfaces of the MACD histogram filter.
interface macdh_req_if #(parameter int PRICE_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] price;
   logic                  first_sample;

   modport source (output valid, output price, output first_sample, input ready);
   modport sink (input valid, input price, input first_sample, output ready);
endinterface

interface macdh_rsp_if #(parameter int PRICE_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [PRICE_BITS+1:0] histogram;

   modport source (output valid, output histogram, input ready);
   modport sink (input valid, input histogram, output ready);
endinterface

// ===== hdl/macdh_csr.sv =====
// APB register bank holding the three smoothing factors.
module macdh_csr import macdh_pkg::*; #(
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [ALPHA_FRAC_BITS:0] alpha_long,
   output logic [ALPHA_FRAC_BITS:0] alpha_short,
   output logic [ALPHA_FRAC_BITS:0] alpha_signal
);

   localparam int AW = ALPHA_FRAC_BITS + 1;
   localparam logic [AW-1:0] LONG_RESET =
      AW'(((2 << ALPHA_FRAC_BITS) + (PERIOD_LONG + 1) / 2) / (PERIOD_LONG + 1));
   localparam logic [AW-1:0] SHORT_RESET =
      AW'(((2 << ALPHA_FRAC_BITS) + (PERIOD_SHORT + 1) / 2) / (PERIOD_SHORT + 1));
   localparam logic [AW-1:0] SIGNAL_RESET =
      AW'(((2 << ALPHA_FRAC_BITS) + (PERIOD_SIGNAL + 1) / 2) / (PERIOD_SIGNAL + 1));

   typedef enum logic [1:0] {
      REG_ALPHA_LONG,
      REG_ALPHA_SHORT,
      REG_ALPHA_SIGNAL
   } reg_index_type;

   logic [AW-1:0] long_ff, long_in;
   logic [AW-1:0] short_ff, short_in;
   logic [AW-1:0] signal_ff, signal_in;
   reg_index_type index;
   logic          wr_en;

   always_comb begin
      index     = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
      wr_en     = psel & penable & pwrite;
      long_in   = long_ff;
      short_in  = short_ff;
      signal_in = signal_ff;
      if (wr_en) begin
         case (index)
            REG_ALPHA_LONG:   long_in   = pwdata[AW-1:0];
            REG_ALPHA_SHORT:  short_in  = pwdata[AW-1:0];
            REG_ALPHA_SIGNAL: signal_in = pwdata[AW-1:0];
            default: ;
         endcase
      end
      case (index)
         REG_ALPHA_LONG:   prdata = CSR_DATA_BITS'(long_ff);
         REG_ALPHA_SHORT:  prdata = CSR_DATA_BITS'(short_ff);
         REG_ALPHA_SIGNAL: prdata = CSR_DATA_BITS'(signal_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff   <= LONG_RESET;
         short_ff  <= SHORT_RESET;
         signal_ff <= SIGNAL_RESET;
      end else begin
         long_ff   <= long_in;
         short_ff  <= short_in;
         signal_ff <= signal_in;
      end
   end

   assign pready       = 1'b1;
   assign alpha_long   = long_ff;
   assign alpha_short  = short_ff;
   assign alpha_signal = signal_ff;

endmodule

// ===== hdl/macdh_sequencer.sv =====
// Microcode step counter with hold and jump conditions and request intake.
module macdh_sequencer import macdh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_first_sample,
   output logic       req_ready,
   input  status_type status,
   output ctrl_type   ctrl
);

   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic               seed_ff, seed_in;
   uword_type          word;
   logic               hold;
   logic               taken;
   logic               accept;

   always_comb begin
      word      = ucode_fetch(pc_ff);
      req_ready = (word.op == OP_LOAD);
      accept    = req_valid & req_ready;
      case (word.hold)
         HOLD_NO_REQ:   hold = ~req_valid;
         HOLD_OUT_BUSY: hold = status.out_busy;
         default:       hold = 1'b0;
      endcase
      case (word.jump)
         JMP_SEED:   taken = seed_ff;
         JMP_ALWAYS: taken = 1'b1;
         default:    taken = 1'b0;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
      seed_in      = accept ? req_first_sample : seed_ff;
      ctrl.op      = word.op;
      ctrl.sel     = word.sel;
      ctrl.load    = accept;
      ctrl.advance = ~hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_LOAD;
         seed_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         seed_ff <= seed_in;
      end
   end

`ifndef ASSERT_OFF
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= STEP_LAST)
      else $error("step counter left the program");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> pc_ff == STEP_LOAD + 1'b1)
      else $error("accepted request did not start the program");

   a_hist_returns: assert property (@(posedge clock) disable iff (reset)
      pc_ff == STEP_HIST && !status.out_busy |=> pc_ff == STEP_LOAD)
      else $error("program did not return after result");
`endif

endmodule

// ===== hdl/macdh_datapath.sv =====
// Averages, shared multiplier, accumulator and response register.
module macdh_datapath import macdh_pkg::*; #(
   parameter int PRICE_BITS      = 32,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_type                     ctrl,
   output status_type                   status,
   input  logic [ALPHA_FRAC_BITS:0]     alpha_long,
   input  logic [ALPHA_FRAC_BITS:0]     alpha_short,
   input  logic [ALPHA_FRAC_BITS:0]     alpha_signal,
   input  logic [PRICE_BITS-1:0]        req_price,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [PRICE_BITS+1:0] rsp_histogram
);

   localparam int AW        = ALPHA_FRAC_BITS + 1;
   localparam int AVG_BITS  = PRICE_BITS + AVG_EXTRA;
   localparam int SIG_BITS  = AVG_BITS + 2;
   localparam int HIST_BITS = PRICE_BITS + 2;
   localparam int DIFF_BITS = SIG_BITS + 1;
   localparam int LO_BITS   = (DIFF_BITS + 1) / 2;
   localparam int PROD_BITS = AW + LO_BITS + 2;
   localparam int ACC_BITS  = AW + DIFF_BITS + 1;
   localparam int STEP_BITS = ACC_BITS - ALPHA_FRAC_BITS;
   localparam int SUM_BITS  = STEP_BITS + 1;
   localparam int HD_BITS   = SIG_BITS + 1;
   localparam int HS_BITS   = HD_BITS - AVG_EXTRA;

   localparam logic signed [SUM_BITS-1:0] AVG_MAX =
      {{(SUM_BITS - AVG_BITS){1'b0}}, {AVG_BITS{1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SIG_MAX =
      {{(SUM_BITS - SIG_BITS + 1){1'b0}}, {(SIG_BITS - 1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SIG_MIN = ~SIG_MAX;
   localparam logic signed [HIST_BITS-1:0] HIST_MAX = {1'b0, {(HIST_BITS - 1){1'b1}}};
   localparam logic signed [HIST_BITS-1:0] HIST_MIN = ~HIST_MAX;

   logic        [AVG_BITS-1:0]  long_ff, long_in;
   logic        [AVG_BITS-1:0]  short_ff, short_in;
   logic signed [SIG_BITS-1:0]  sig_ff, sig_in;
   logic        [AVG_BITS-1:0]  x_ff, x_in;
   logic signed [AVG_BITS:0]    macd_ff, macd_in;
   logic signed [DIFF_BITS-1:0] d_ff, d_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [HIST_BITS-1:0] hist_ff, hist_in;

   logic [AW-1:0]               alpha;
   logic signed [DIFF_BITS-1:0] avg_cur;
   logic signed [DIFF_BITS-1:0] tgt;
   logic signed [AW:0]          mul_a;
   logic signed [LO_BITS:0]     mul_b;
   logic signed [PROD_BITS-1:0] mul_p;
   logic signed [STEP_BITS-1:0] step;
   logic signed [SUM_BITS-1:0]  sum;
   logic        [AVG_BITS-1:0]  sum_avg;
   logic signed [SIG_BITS-1:0]  sum_sig;
   logic signed [HD_BITS-1:0]   hd;
   logic signed [HS_BITS-1:0]   hs;
   logic                        out_busy;

   always_comb begin
      out_busy = rsp_valid_ff & ~rsp_ready;

      case (ctrl.sel)
         SEL_LONG: begin
            alpha   = alpha_long;
            avg_cur = signed'(DIFF_BITS'(long_ff));
            tgt     = signed'(DIFF_BITS'(x_ff));
         end
         SEL_SHORT: begin
            alpha   = alpha_short;
            avg_cur = signed'(DIFF_BITS'(short_ff));
            tgt     = signed'(DIFF_BITS'(x_ff));
         end
         SEL_SIGNAL: begin
            alpha   = alpha_signal;
            avg_cur = DIFF_BITS'(sig_ff);
            tgt     = DIFF_BITS'(macd_ff);
         end
         default: begin
            alpha   = alpha_long;
            avg_cur = signed'(DIFF_BITS'(long_ff));
            tgt     = signed'(DIFF_BITS'(x_ff));
         end
      endcase

      mul_a = signed'({1'b0, alpha});
      if (ctrl.op == OP_MUL_HI) begin
         mul_b = (LO_BITS + 1)'(signed'(d_ff[DIFF_BITS-1:LO_BITS]));
      end else begin
         mul_b = signed'({1'b0, d_ff[LO_BITS-1:0]});
      end
      mul_p = PROD_BITS'(mul_a * mul_b);

      step    = STEP_BITS'(acc_ff >>> ALPHA_FRAC_BITS);
      sum     = SUM_BITS'(avg_cur) + SUM_BITS'(step);
      if (sum < 0) begin
         sum_avg = '0;
      end else if (sum > AVG_MAX) begin
         sum_avg = AVG_MAX[AVG_BITS-1:0];
      end else begin
         sum_avg = sum[AVG_BITS-1:0];
      end
      if (sum < SIG_MIN) begin
         sum_sig = SIG_MIN[SIG_BITS-1:0];
      end else if (sum > SIG_MAX) begin
         sum_sig = SIG_MAX[SIG_BITS-1:0];
      end else begin
         sum_sig = sum[SIG_BITS-1:0];
      end

      hd = HD_BITS'(macd_ff) - HD_BITS'(sig_ff);
      hs = HS_BITS'(hd >>> AVG_EXTRA);

      long_in      = long_ff;
      short_in     = short_ff;
      sig_in       = sig_ff;
      x_in         = x_ff;
      macd_in      = macd_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      hist_in      = hist_ff;
      rsp_valid_in = out_busy;

      if (ctrl.load) begin
         x_in = {req_price, {AVG_EXTRA{1'b0}}};
      end

      case (ctrl.op)
         OP_DIFF: begin
            d_in = tgt - avg_cur;
         end
         OP_MUL_HI: begin
            prod_in = mul_p;
         end
         OP_MUL_LO: begin
            acc_in  = ACC_BITS'(prod_ff) <<< LO_BITS;
            prod_in = mul_p;
         end
         OP_ACC: begin
            acc_in = acc_ff + ACC_BITS'(prod_ff);
         end
         OP_UPDATE: begin
            case (ctrl.sel)
               SEL_LONG:   long_in  = sum_avg;
               SEL_SHORT:  short_in = sum_avg;
               SEL_SIGNAL: sig_in   = sum_sig;
               default: ;
            endcase
         end
         OP_MACD: begin
            macd_in = signed'({1'b0, short_ff}) - signed'({1'b0, long_ff});
         end
         OP_HIST: begin
            if (ctrl.advance) begin
               rsp_valid_in = 1'b1;
               if (hs[HS_BITS-1] != hs[HS_BITS-2]) begin
                  hist_in = hs[HS_BITS-1] ? HIST_MIN : HIST_MAX;
               end else begin
                  hist_in = hs[HIST_BITS-1:0];
               end
            end
         end
         OP_SEED: begin
            long_in  = x_ff;
            short_in = x_ff;
            sig_in   = '0;
            macd_in  = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ff      <= '0;
         short_ff     <= '0;
         sig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         long_ff      <= long_in;
         short_ff     <= short_in;
         sig_ff       <= sig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      macd_ff <= macd_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      hist_ff <= hist_in;
   end

   assign status.out_busy = out_busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_histogram   = hist_ff;

endmodule

// ===== hdl/macd_histogram_filter.sv =====
// Top level of the streaming MACD histogram filter.
//
// Requests on req_ch carry one closing price (unsigned Q16.16) and a flag that
// marks the first sample of a series; each request yields one signed Q18.16
// histogram value (short EMA - long EMA - signal EMA) on rsp_ch. Both channels
// move a request when valid and ready are high at a rising clock edge.
// The APB port holds the long, short and signal smoothing factors (Q1.16) at
// byte addresses 0, 4 and 8; pready is always high.
// A microcoded sequencer drives one shared multiplier, two passes per average.
// A first sample seeds the averages and skips the multiplier; any other sample
// runs the six multiplier passes and their accumulate and update steps.
// The result sits in an output register, so the next request is taken while
// it waits; the program holds at its final step only when a new result meets
// a previous one that has not been taken.
// Reset (synchronous, active high) restores the default factors for periods
// 26, 12 and 9 and clears all three averages.
module macd_histogram_filter import macdh_pkg::*; #(
   parameter int PRICE_BITS      = 32,
   parameter int ALPHA_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   macdh_req_if.sink                req_ch,
   macdh_rsp_if.source              rsp_ch,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [ALPHA_FRAC_BITS:0] alpha_long;
   logic [ALPHA_FRAC_BITS:0] alpha_short;
   logic [ALPHA_FRAC_BITS:0] alpha_signal;
   ctrl_type                 ctrl;
   status_type               status;

   macdh_csr #(
      .ALPHA_FRAC_BITS(ALPHA_FRAC_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .alpha_long   (alpha_long),
      .alpha_short  (alpha_short),
      .alpha_signal (alpha_signal)
   );

   macdh_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_first_sample (req_ch.first_sample),
      .req_ready        (req_ch.ready),
      .status           (status),
      .ctrl             (ctrl)
   );

   macdh_datapath #(
      .PRICE_BITS      (PRICE_BITS),
      .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .alpha_long    (alpha_long),
      .alpha_short   (alpha_short),
      .alpha_signal  (alpha_signal),
      .req_price     (req_ch.price),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_histogram (rsp_ch.histogram)
   );

endmodule
